@@ rtl/core/ic_pkg.sv @@
package ic_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int GREATER_W = $clog2(MAX_ITEMS);
   localparam int TOTAL_W   = 19;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef struct packed {
      logic signed [63:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] inversion_total;
      logic               overflowed;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic                 counted;
      logic                 placed;
      logic signed [63:0]   value;
      logic [GREATER_W-1:0] greater;
   } token_type;

endpackage

@@ rtl/core/ic_cell.sv @@
module ic_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ic_pkg::token_type token_in,
   output ic_pkg::token_type token_out
);

   logic                     occupied_ff;
   logic                     occupied_in;
   logic signed [63:0]       held_ff;
   logic signed [63:0]       held_in;
   ic_pkg::token_type        token_ff;
   ic_pkg::token_type        token_in_nxt;
   logic                     in_use;
   logic                     hit;
   logic                     place;

   always_comb begin
      in_use       = token_in.valid && token_in.counted;
      hit          = in_use && occupied_ff && (held_ff > token_in.value);
      place        = in_use && !occupied_ff && !token_in.placed;
      token_in_nxt = token_in;
      if (hit) begin
         token_in_nxt.greater = token_in.greater + ic_pkg::GREATER_W'(1);
      end
      if (place) begin
         token_in_nxt.placed = 1'b1;
      end
      held_in = place ? token_in.value : held_ff;
      if (token_in.valid && token_in.last) begin
         occupied_in = 1'b0;
      end else if (place) begin
         occupied_in = 1'b1;
      end else begin
         occupied_in = occupied_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff    <= 1'b0;
         token_ff.valid <= 1'b0;
      end else if (advance) begin
         occupied_ff    <= occupied_in;
         token_ff.valid <= token_in_nxt.valid;
      end
      if (advance) begin
         held_ff          <= held_in;
         token_ff.last    <= token_in_nxt.last;
         token_ff.counted <= token_in_nxt.counted;
         token_ff.placed  <= token_in_nxt.placed;
         token_ff.value   <= token_in_nxt.value;
         token_ff.greater <= token_in_nxt.greater;
      end
   end

   assign token_out = token_ff;

endmodule

@@ rtl/core/ic_tail.sv @@
module ic_tail (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ic_pkg::token_type token_in,
   output logic              rsp_valid,
   output ic_pkg::rsp_type   rsp_data
);

   logic [ic_pkg::TOTAL_W-1:0] total_ff;
   logic [ic_pkg::TOTAL_W-1:0] total_in;
   logic                       overflow_ff;
   logic                       overflow_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   ic_pkg::rsp_type            rsp_ff;
   ic_pkg::rsp_type            rsp_in;
   logic [ic_pkg::TOTAL_W:0]   sum;
   logic [ic_pkg::TOTAL_W-1:0] sum_sat;
   logic                       ovf_now;
   logic                       emit;

   always_comb begin
      sum     = {1'b0, total_ff} + (ic_pkg::TOTAL_W + 1)'(token_in.greater);
      sum_sat = (sum > {1'b0, ic_pkg::TOTAL_MAX}) ? ic_pkg::TOTAL_MAX
                                                  : sum[ic_pkg::TOTAL_W-1:0];
      ovf_now = overflow_ff || !token_in.counted;
      emit    = token_in.valid && token_in.last;
      rsp_in.inversion_total = sum_sat;
      rsp_in.overflowed      = ovf_now;
      total_in     = total_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
         if (token_in.valid) begin
            total_in    = emit ? '0 : sum_sat;
            overflow_in = emit ? 1'b0 : ovf_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/inversion_counter_unit.sv @@
// Inversion counter over signed 64-bit values.
// Request channel (req_valid, req_stall, req_data): one value per request,
// with last marking the final value of a sequence. Only a last request
// produces a response on rsp_valid, rsp_stall, rsp_data: the number of
// earlier-greater pairs of the sequence and an overflow flag.
// Each request travels down a row of MAX_ITEMS compare cells; each cell
// holds one value of the current sequence. A response is registered in the
// tail once its last request has passed through every cell.
// Throughput is one request per cycle, back to back, across sequences, while the row is not frozen.
// Values past MAX_ITEMS in a sequence are dropped and set the overflow flag.
// Reset empties every cell and clears the running total; no sweep is needed.
// While a response waits under rsp_stall the whole row freezes and
// req_stall is raised; the row resumes once the response is taken.
module inversion_counter_unit (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ic_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ic_pkg::rsp_type rsp_data
);

   logic [ic_pkg::COUNT_W-1:0] count_ff;
   logic [ic_pkg::COUNT_W-1:0] count_in;
   logic                       advance;
   logic                       counted;
   ic_pkg::token_type          head;
   ic_pkg::token_type          chain [0:ic_pkg::MAX_ITEMS];

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign counted   = count_ff != ic_pkg::COUNT_W'(ic_pkg::MAX_ITEMS);
   assign chain[0]  = head;

   always_comb begin
      head.valid   = req_valid;
      head.last    = req_data.last;
      head.counted = counted;
      head.placed  = 1'b0;
      head.value   = req_data.value;
      head.greater = '0;
      count_in = count_ff;
      if (advance && req_valid) begin
         if (req_data.last) begin
            count_in = '0;
         end else if (counted) begin
            count_in = count_ff + ic_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar k = 0; k < ic_pkg::MAX_ITEMS; k++) begin : g_cell
      ic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .token_in  (chain[k]),
         .token_out (chain[k+1])
      );
   end

   ic_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .token_in  (chain[ic_pkg::MAX_ITEMS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam logic signed [63:0] VALUE_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam logic signed [63:0] VALUE_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] ALT_LOW   = 64'sh5555_5555_5555_5555;
   localparam logic signed [63:0] ALT_HIGH  = 64'shaaaa_aaaa_aaaa_aaaa;
   localparam int RANDOM_REQUESTS = 500;

   typedef struct {
      logic signed [63:0]         value;
      bit                         last;
      bit                         typed;
      logic [ic_pkg::TOTAL_W-1:0] total;
      bit                         overflowed;
   } stim_row;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   ic_pkg::req_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   ic_pkg::rsp_type rsp_data;

   logic signed [63:0] seen_values [ic_pkg::MAX_ITEMS];
   int unsigned        seen_count = 0;
   int unsigned        pair_total = 0;
   bit                 spill = 1'b0;
   ic_pkg::rsp_type    expected_totals [$];
   int unsigned        mismatch_count = 0;
   int unsigned        rsp_hold = 0;
   bit                 quiet = 1'b0;

   stim_row directed_rows [22] = '{
      '{64'sd0,    1'b1, 1'b1, 19'd0, 1'b0},
      '{VALUE_MAX, 1'b1, 1'b1, 19'd0, 1'b0},
      '{VALUE_MIN, 1'b1, 1'b1, 19'd0, 1'b0},
      '{VALUE_MAX, 1'b0, 1'b0, 19'd0, 1'b0},
      '{VALUE_MIN, 1'b1, 1'b1, 19'd1, 1'b0},
      '{VALUE_MIN, 1'b0, 1'b0, 19'd0, 1'b0},
      '{VALUE_MAX, 1'b1, 1'b1, 19'd0, 1'b0},
      '{64'sd5,    1'b0, 1'b0, 19'd0, 1'b0},
      '{64'sd5,    1'b0, 1'b0, 19'd0, 1'b0},
      '{64'sd5,    1'b1, 1'b1, 19'd0, 1'b0},
      '{-64'sd1,   1'b0, 1'b0, 19'd0, 1'b0},
      '{64'sd0,    1'b0, 1'b0, 19'd0, 1'b0},
      '{-64'sd1,   1'b0, 1'b0, 19'd0, 1'b0},
      '{64'sd1,    1'b1, 1'b0, 19'd0, 1'b0},
      '{VALUE_MAX, 1'b0, 1'b0, 19'd0, 1'b0},
      '{-64'sd1,   1'b0, 1'b0, 19'd0, 1'b0},
      '{64'sd0,    1'b0, 1'b0, 19'd0, 1'b0},
      '{VALUE_MIN, 1'b1, 1'b0, 19'd0, 1'b0},
      '{ALT_LOW,   1'b0, 1'b0, 19'd0, 1'b0},
      '{ALT_HIGH,  1'b1, 1'b1, 19'd1, 1'b0},
      '{ALT_HIGH,  1'b0, 1'b0, 19'd0, 1'b0},
      '{ALT_LOW,   1'b1, 1'b1, 19'd0, 1'b0}
   };

   inversion_counter_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic void tally_request(input ic_pkg::req_type r, output bit closes,
                                         output ic_pkg::rsp_type res);
      int unsigned above;
      closes = r.last;
      res = '0;
      if (seen_count < ic_pkg::MAX_ITEMS) begin
         above = 0;
         for (int k = 0; k < seen_count; k++) begin
            if ($signed(seen_values[k]) > $signed(r.value)) above++;
         end
         pair_total += above;
         seen_values[seen_count] = r.value;
         seen_count++;
      end else begin
         spill = 1'b1;
      end
      if (closes) begin
         res.inversion_total = (pair_total > ic_pkg::TOTAL_MAX) ?
                               ic_pkg::TOTAL_MAX : pair_total[ic_pkg::TOTAL_W-1:0];
         res.overflowed = spill;
         seen_count = 0;
         pair_total = 0;
         spill = 1'b0;
      end
   endfunction

   function automatic void compare_total(input ic_pkg::rsp_type got);
      ic_pkg::rsp_type want;
      if (expected_totals.size() == 0) begin
         $error("unexpected response: inversion_total %0d overflowed %0d",
                got.inversion_total, got.overflowed);
         mismatch_count++;
         return;
      end
      want = expected_totals.pop_front();
      if (got.inversion_total !== want.inversion_total) begin
         $error("inversion_total: expected %0d, got %0d",
                want.inversion_total, got.inversion_total);
         mismatch_count++;
      end
      if (got.overflowed !== want.overflowed) begin
         $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
         mismatch_count++;
      end
   endfunction

   function automatic logic signed [63:0] draw_value(input int unsigned mode);
      case (mode)
         0: return {$urandom, $urandom};
         1: return 64'(int'($urandom_range(0, 6)) - 3);
         default: begin
            case ($urandom_range(0, 4))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return 64'sd0;
               3: return -64'sd1;
               default: return {$urandom, $urandom};
            endcase
         end
      endcase
   endfunction

   task automatic send_request(input ic_pkg::req_type r, input bit typed,
                               input ic_pkg::rsp_type typed_rsp);
      int unsigned gap;
      bit closes;
      ic_pkg::rsp_type res;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tally_request(r, closes, res);
      if (closes) expected_totals = {expected_totals, (typed ? typed_rsp : res)};
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         compare_total(rsp_data);
         rsp_hold = quiet ? 0 : $urandom_range(0, 4);
      end else if (!reset && rsp_valid && rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_stall <= (rsp_hold > 0);
   end

   initial begin
      ic_pkg::req_type r;
      ic_pkg::rsp_type want;
      int unsigned sent;
      int unsigned seq_len;
      int unsigned mode;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         r.value = directed_rows[i].value;
         r.last  = directed_rows[i].last;
         want.inversion_total = directed_rows[i].total;
         want.overflowed      = directed_rows[i].overflowed;
         send_request(r, directed_rows[i].typed, want);
      end

      // strictly falling run at full capacity, then two dropped values
      want.inversion_total = ic_pkg::TOTAL_W'(ic_pkg::MAX_ITEMS * (ic_pkg::MAX_ITEMS - 1) / 2);
      want.overflowed = 1'b1;
      for (int k = 0; k < ic_pkg::MAX_ITEMS + 2; k++) begin
         r.value = (k < ic_pkg::MAX_ITEMS) ? 64'(511 - k) : VALUE_MIN;
         r.last  = (k == ic_pkg::MAX_ITEMS + 1);
         send_request(r, 1'b1, want);
      end

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         seq_len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) :
                                                  $urandom_range(1, 24);
         mode  = $urandom_range(0, 2);
         quiet = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < seq_len; k++) begin
            r.value = draw_value(mode);
            r.last  = (k == seq_len - 1);
            send_request(r, 1'b0, '0);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (expected_totals.size() != 0) @(posedge clock);
      repeat (ic_pkg::MAX_ITEMS + 64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/ic_pkg.sv
rtl/core/ic_cell.sv
rtl/core/ic_tail.sv
rtl/core/inversion_counter_unit.sv
tb/tb.sv
